// ===== hw/rtl/opc_pkg.sv =====
// Shared types and constants for the OQAM post-processing combiner.
// No dependencies; used by opc_rotate and oqam_postprocess_combiner.
`default_nettype none

package opc_pkg;

  localparam int unsigned SampleW            = 16;
  localparam int unsigned SubcarriersDefault = 64;

  // Quarter-turn rotation codes, n mod 4.
  typedef enum logic [1:0] {
    PhaseOne    = 2'd0,
    PhaseNegJ   = 2'd1,
    PhaseNegOne = 2'd2,
    PhasePosJ   = 2'd3
  } phase_e;

  // Rotation pattern selected by the mode register.
  typedef enum logic {
    ModeQuarter = 1'b0,
    ModeHalf    = 1'b1
  } mode_e;

  typedef logic signed [SampleW-1:0] sample_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oqam_postprocess_combiner.sv =====
// OQAM post-processing combiner: rotation, first-half store and pairing.
// Depends on opc_pkg, opc_ram and opc_rotate.
//
// Usage:
//   Input words (sample_re_i, sample_im_i) arrive on in_valid_i / in_stall_o,
//   one subcarrier sample per word, SUBCARRIERS words per symbol vector.
//   Vectors come in pairs: the first vector only fills the store and yields
//   no output word; each word of the second vector yields one output word
//   (out_re_o, out_im_o, vector_end_o) on out_valid_o / out_stall_i.
//   The mode register is written through cfg_valid_i / cfg_ready_o /
//   cfg_data_i; cfg_ready_o is always high. Write it only while idle.
//   An input word is held in the input register, where the store read issued
//   at accept lines up with it, and then loaded into the output register.
//   Throughput: one word per cycle unless the receiver stalls, set by the
//   single store read port and the single write port, on different subcarriers.
//   When the receiver stalls, the output register holds its word and the
//   input register fills; in_stall_o rises only when a second-half word
//   sits in the input register and the output register cannot take it.
//   Reset clears the counters, the mode register and all valid flags; the
//   store contents are not cleared and need no clearing pass.
`default_nettype none

module oqam_postprocess_combiner #(
  parameter int unsigned SUBCARRIERS = opc_pkg::SubcarriersDefault,
  localparam int unsigned IdxW = (SUBCARRIERS > 1) ? $clog2(SUBCARRIERS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire opc_pkg::sample_t sample_re_i,
  input  wire opc_pkg::sample_t sample_im_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output opc_pkg::sample_t      out_re_o,
  output opc_pkg::sample_t      out_im_o,
  output logic                  vector_end_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SUBCARRIERS - 1);

  // Control state
  opc_pkg::mode_e  mode_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            half_q, half_d;
  logic [1:0]      sym_phase_q, sym_phase_d;

  // Input register
  logic             s1_valid_q;
  opc_pkg::sample_t s1_re_q, s1_im_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic             s1_half_q;
  logic             s1_last_q;
  opc_pkg::phase_e  s1_phase_q;
  opc_pkg::mode_e   s1_mode_q;

  // Output register
  logic             out_valid_q;
  opc_pkg::sample_t out_re_q, out_im_q;
  logic             out_end_q;

  logic             in_accept;
  logic             last_now;
  opc_pkg::phase_e  phase_now;
  logic             out_free;
  logic             out_load;
  logic             s1_advance;
  logic             store_we;
  opc_pkg::sample_t rot_real;
  logic [opc_pkg::SampleW-1:0] store_rdata;

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  // First-half words only write the store and never wait for the output side.
  assign s1_advance = !s1_half_q || out_free;
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = s1_valid_q && s1_half_q && out_free;
  assign store_we   = s1_valid_q && !s1_half_q;

  assign last_now  = (idx_q == LastIdx);
  assign phase_now = opc_pkg::phase_e'(sym_phase_q + 2'(idx_q));

  always_comb begin
    idx_d       = idx_q;
    half_d      = half_q;
    sym_phase_d = sym_phase_q;
    if (in_accept) begin
      if (last_now) begin
        idx_d       = '0;
        half_d      = !half_q;
        sym_phase_d = sym_phase_q + 2'd1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= opc_pkg::ModeQuarter;
      idx_q       <= '0;
      half_q      <= 1'b0;
      sym_phase_q <= 2'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= opc_pkg::mode_e'(cfg_data_i);
      end
      idx_q       <= idx_d;
      half_q      <= half_d;
      sym_phase_q <= sym_phase_d;
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_re_q    <= sample_re_i;
      s1_im_q    <= sample_im_i;
      s1_idx_q   <= idx_q;
      s1_half_q  <= half_q;
      s1_last_q  <= last_now;
      s1_phase_q <= phase_now;
      s1_mode_q  <= mode_q;
    end
    if (out_load) begin
      // Even subcarriers pair (stored, new); odd subcarriers swap them.
      out_re_q  <= s1_idx_q[0] ? rot_real : opc_pkg::sample_t'(store_rdata);
      out_im_q  <= s1_idx_q[0] ? opc_pkg::sample_t'(store_rdata) : rot_real;
      out_end_q <= s1_last_q;
    end
  end

  opc_rotate u_rotate (
    .re_i    (s1_re_q),
    .im_i    (s1_im_q),
    .phase_i (s1_phase_q),
    .mode_i  (s1_mode_q),
    .real_o  (rot_real)
  );

  // The read is issued at accept, so its data lines up with the input register
  // and holds while that word waits.
  opc_ram #(
    .Width (opc_pkg::SampleW),
    .Depth (SUBCARRIERS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_idx_q),
    .wdata_i (rot_real),
    .re_i    (in_accept),
    .raddr_i (idx_q),
    .rdata_o (store_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_re_o     = out_re_q;
  assign out_im_o     = out_im_q;
  assign vector_end_o = out_end_q;

`ifndef ASSERT_OFF
  a_first_half_flows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_half_q) |-> !in_stall_o)
    else $error("first-half word blocked the input");

  a_stall_needs_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_half_q && out_valid_q && out_stall_i))
    else $error("input stalled without a waiting second-half word");

  a_phase_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_now) |=> (idx_q == '0)
                               && (sym_phase_q == $past(sym_phase_q) + 2'd1)
                               && (half_q != $past(half_q)))
    else $error("vector end did not advance the symbol state");

  a_no_output_first_half : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> s1_half_q)
    else $error("output produced from a first-half word");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/opc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module opc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/opc_rotate.sv =====
// Real part of one complex sample after rotation by 1, -j, -1 or j.
// Depends on opc_pkg for the phase and mode codes.
`default_nettype none

module opc_rotate (
  input  wire opc_pkg::sample_t re_i,
  input  wire opc_pkg::sample_t im_i,
  input  wire opc_pkg::phase_e  phase_i,
  input  wire opc_pkg::mode_e   mode_i,
  output opc_pkg::sample_t      real_o
);

  localparam opc_pkg::sample_t MinVal = {1'b1, {(opc_pkg::SampleW-1){1'b0}}};
  localparam opc_pkg::sample_t MaxVal = {1'b0, {(opc_pkg::SampleW-1){1'b1}}};

  opc_pkg::sample_t neg_re;
  opc_pkg::sample_t neg_im;

  // Negating the most negative value saturates to the most positive one.
  assign neg_re = (re_i == MinVal) ? MaxVal : -re_i;
  assign neg_im = (im_i == MinVal) ? MaxVal : -im_i;

  always_comb begin
    real_o = re_i;
    unique case (mode_i)
      opc_pkg::ModeHalf: begin
        real_o = phase_i[0] ? im_i : re_i;
      end
      opc_pkg::ModeQuarter: begin
        unique case (phase_i)
          opc_pkg::PhaseOne:    real_o = re_i;
          opc_pkg::PhaseNegJ:   real_o = im_i;
          opc_pkg::PhaseNegOne: real_o = neg_re;
          opc_pkg::PhasePosJ:   real_o = neg_im;
          default:              real_o = re_i;
        endcase
      end
      default: real_o = re_i;
    endcase
  end

endmodule

`default_nettype wire
